@@ hdl/sbsh_pkg.sv @@
// ----------------------------------------------------------------------------
// sbsh_pkg
// Shared types, constants and SHA-256 helper functions for the byte stream
// hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sbsh_pkg;

  // Operation codes carried by an input item.
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_DATA   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  // Padding marker byte and the position where the length field starts.
  localparam logic [7:0] PAD_MARKER = 8'h80;
  localparam logic [2:0] LEN_ZONE   = 3'b111;

  typedef logic [31:0] word_arr_t [8];

  // Control from the sequencer to the message schedule.
  typedef struct packed {
    logic byte_we;
    logic last_lane;
    logic step;
  } sbsh_sched_ctrl_t;

  // Initial hash value.
  localparam word_arr_t HASH_IV = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constants.
  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Small sigma functions of the message schedule.
  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

  // Large sigma functions of the round.
  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

endpackage

`default_nettype wire

@@ hdl/sbsh_msg_sched.sv @@
// ----------------------------------------------------------------------------
// sbsh_msg_sched
// Sixteen-word message window. Bytes are packed into big-endian words and
// shifted in; during compression the same window rolls forward and yields
// one schedule word per round.
// ----------------------------------------------------------------------------
`default_nettype none

module sbsh_msg_sched (
  input  wire                             clk_i,
  input  wire sbsh_pkg::sbsh_sched_ctrl_t ctrl_i,
  input  wire  [7:0]                      byte_i,
  output logic [31:0]                     w_o
);

  logic [23:0] acc_q;
  logic [31:0] win_q [16];
  logic [31:0] next_w;
  logic [31:0] shift_in;
  logic        shift_en;

  // Next schedule word from the taps of the window.
  assign next_w = sbsh_pkg::sig1(win_q[14]) + win_q[9] + sbsh_pkg::sig0(win_q[1]) + win_q[0];

  assign shift_en = ctrl_i.step | (ctrl_i.byte_we & ctrl_i.last_lane);
  assign shift_in = ctrl_i.step ? next_w : {acc_q, byte_i};

  // Byte packing into the partial word.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.byte_we && !ctrl_i.last_lane) begin
      acc_q <= {acc_q[15:0], byte_i};
    end
  end

  // The window shifts by one word on a full word or a round.
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= shift_in;
    end
  end

  assign w_o = win_q[0];

endmodule

`default_nettype wire

@@ hdl/sbsh_round.sv @@
// ----------------------------------------------------------------------------
// sbsh_round
// One SHA-256 compression round: the shared unit that the sequencer applies
// to the working variables once per cycle while compressing a block.
// ----------------------------------------------------------------------------
`default_nettype none

module sbsh_round (
  input  wire sbsh_pkg::word_arr_t vars_i,
  input  wire  [31:0]              w_i,
  input  wire  [5:0]               round_i,
  output sbsh_pkg::word_arr_t      vars_o
);

  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  // Choice, majority and the two temporaries.
  always_comb begin
    ch  = (vars_i[4] & vars_i[5]) ^ (~vars_i[4] & vars_i[6]);
    maj = (vars_i[0] & vars_i[1]) ^ (vars_i[0] & vars_i[2]) ^ (vars_i[1] & vars_i[2]);
    t1  = vars_i[7] + sbsh_pkg::bsig1(vars_i[4]) + ch + sbsh_pkg::ROUND_K[round_i] + w_i;
    t2  = sbsh_pkg::bsig0(vars_i[0]) + maj;
  end

  // Rotate the working variables.
  always_comb begin
    vars_o[7] = vars_i[6];
    vars_o[6] = vars_i[5];
    vars_o[5] = vars_i[4];
    vars_o[4] = vars_i[3] + t1;
    vars_o[3] = vars_i[2];
    vars_o[2] = vars_i[1];
    vars_o[1] = vars_i[0];
    vars_o[0] = t1 + t2;
  end

endmodule

`default_nettype wire

@@ hdl/sha256_byte_stream_hasher_core.sv @@
// A start item or a data byte is taken while the core is idle; a byte that completes
// a block starts compression: one round per cycle over 64 rounds, then a fold.
// A finish item pads one byte per cycle up to the block end, compresses each
// block (one or two blocks) and then offers eight digest items.
// Input stalls while the core pads, uses the single shared round unit or emits digests.
// Reset is asynchronous and active low; it loads the initial hash and clears the counters.
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_core
// SHA-256 engine fed one byte per item, with a small sequencer around one
// shared round unit and a rolling message window.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_byte_stream_hasher_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  operation_i,
  input  wire  [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_FOLD  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [5:0]  bytes_held_q, bytes_held_d;
  logic [63:0] bit_length_q, bit_length_d;
  logic [5:0]  round_q, round_d;
  logic [2:0]  idx_q, idx_d;
  logic        fin_q, fin_d;
  logic        extra_q, extra_d;

  sbsh_pkg::word_arr_t chain_q;
  sbsh_pkg::word_arr_t vars_q;
  sbsh_pkg::word_arr_t vars_next;

  sbsh_pkg::sbsh_sched_ctrl_t sched_ctrl;
  logic [31:0] sched_w;
  logic [7:0]  push_byte;
  logic        push_en;
  logic        load_vars;
  logic        fold_en;
  logic        load_iv;
  logic [7:0]  len_byte;

  // Length byte for the current position within the trailing length field.
  assign len_byte = bit_length_q[{~bytes_held_q[2:0], 3'b000} +: 8];

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    bytes_held_d = bytes_held_q;
    bit_length_d = bit_length_q;
    round_d      = round_q;
    idx_d        = idx_q;
    fin_d        = fin_q;
    extra_d      = extra_q;
    push_en      = 1'b0;
    push_byte    = data_byte_i;
    load_vars    = 1'b0;
    fold_en      = 1'b0;
    load_iv      = 1'b0;
    sched_ctrl   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (operation_i)
            sbsh_pkg::OP_START: begin
              load_iv      = 1'b1;
              bytes_held_d = '0;
              bit_length_d = '0;
            end
            sbsh_pkg::OP_DATA: begin
              push_en      = 1'b1;
              bit_length_d = bit_length_q + 64'd8;
              fin_d        = 1'b0;
            end
            sbsh_pkg::OP_FINISH: begin
              push_en   = 1'b1;
              push_byte = sbsh_pkg::PAD_MARKER;
              fin_d     = 1'b1;
              extra_d   = (bytes_held_q[5:3] == sbsh_pkg::LEN_ZONE);
              state_d   = ST_PAD;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PAD: begin
        push_en   = 1'b1;
        push_byte = (!extra_q && bytes_held_q[5:3] == sbsh_pkg::LEN_ZONE) ? len_byte : 8'h00;
      end
      ST_ROUND: begin
        sched_ctrl.step = 1'b1;
        round_d         = round_q + 6'd1;
        if (round_q == 6'd63) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        fold_en = 1'b1;
        if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (extra_q) begin
          extra_d = 1'b0;
          state_d = ST_PAD;
        end else begin
          idx_d   = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_stall_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A byte goes into the window; a full block starts the compression.
    if (push_en) begin
      sched_ctrl.byte_we   = 1'b1;
      sched_ctrl.last_lane = (bytes_held_q[1:0] == 2'b11);
      bytes_held_d         = bytes_held_q + 6'd1;
      if (bytes_held_q == 6'd63) begin
        load_vars = 1'b1;
        state_d   = ST_ROUND;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      bytes_held_q <= '0;
      bit_length_q <= '0;
      round_q      <= '0;
      idx_q        <= '0;
      fin_q        <= 1'b0;
      extra_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      bytes_held_q <= bytes_held_d;
      bit_length_q <= bit_length_d;
      round_q      <= round_d;
      idx_q        <= idx_d;
      fin_q        <= fin_d;
      extra_q      <= extra_d;
    end
  end

  // Chain value: initial hash on reset or start, folded after each block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= sbsh_pkg::HASH_IV;
    end else if (load_iv) begin
      chain_q <= sbsh_pkg::HASH_IV;
    end else if (fold_en) begin
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= chain_q[i] + vars_q[i];
      end
    end
  end

  // Working variables.
  always_ff @(posedge clk_i) begin
    if (load_vars) begin
      vars_q <= chain_q;
    end else if (sched_ctrl.step) begin
      vars_q <= vars_next;
    end
  end

  sbsh_msg_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .byte_i (push_byte),
    .w_o    (sched_w)
  );

  sbsh_round u_round (
    .vars_i  (vars_q),
    .w_i     (sched_w),
    .round_i (round_q),
    .vars_o  (vars_next)
  );

  // Handshake and result item.
  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = (state_q == ST_EMIT);
  assign digest_word_o = chain_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == 3'd7);

`ifndef SYNTHESIS
  // No input item is taken while digest items are offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> in_stall_o)
    else $error("input accepted during digest output");

  // The round counter rests at zero outside compression.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_ROUND) |-> (round_q == 6'd0))
    else $error("round counter not at zero outside compression");

  // The block buffer is empty whenever the digest is offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bytes_held_q == 6'd0))
    else $error("bytes left over at digest output");

  // Output ends after the last word is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_word_o && !out_stall_i) |=> !out_valid_o)
    else $error("digest output continues past the last word");
`endif

endmodule

`default_nettype wire

@@ verif/sha256_byte_stream_hasher_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_core_test
// Self-checking bench for the byte stream SHA-256 core. A queue of start,
// data, finish and unused items feeds a bursty driver. Every accepted item
// runs through a bench-side SHA-256 model, which queues the eight digest
// words that a finish item must produce. A monitor under a varying stall
// pattern compares each digest item field by field.
// ----------------------------------------------------------------------------

module sha256_byte_stream_hasher_core_test;

  // Operation code that the core must ignore.
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         ITEM_TARGET = 370;
  localparam int         HOLD_CYCLES = 1200;
  localparam int         HOLD_AFTER  = 56;

  typedef logic [31:0] hash_words_t [8];

  // Initial hash value of SHA-256.
  localparam hash_words_t SHA_START_HASH = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constants of SHA-256.
  localparam logic [31:0] SHA_ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // One input item, with a flag that makes the driver wait for an idle core.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] value;
    logic       wait_idle;
  } hash_item_t;

  // One digest item as the core should present it.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic [1:0]  in_op = sbsh_pkg::OP_START;
  logic [7:0]  in_byte = 8'h00;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  hash_item_t   pending_q[$];
  digest_item_t digest_q[$];
  int unsigned  planned_items = 0;
  int unsigned  words_due = 0;
  int unsigned  words_seen = 0;
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;

  // Bench copy of the hash state, starting from the state after reset.
  logic [31:0] chain_hash [8] = SHA_START_HASH;
  logic [7:0]  msg_block [64];
  logic [5:0]  fill_count = '0;
  logic [63:0] msg_bits = '0;

  sha256_byte_stream_hasher_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .operation_i  (in_op),
    .data_byte_i  (in_byte),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .digest_word_o(digest_word),
    .word_index_o (word_index),
    .last_word_o  (last_word)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [31:0] rot_right(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Compresses msg_block into chain_hash with the full 64-word schedule.
  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int t = 0; t < 16; t++) begin
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    end
    for (int t = 16; t < 64; t++) begin
      s0 = rot_right(w[t-15], 7) ^ rot_right(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rot_right(w[t-2], 17) ^ rot_right(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    a = chain_hash[0]; b = chain_hash[1]; c = chain_hash[2]; d = chain_hash[3];
    e = chain_hash[4]; f = chain_hash[5]; g = chain_hash[6]; h = chain_hash[7];
    for (int t = 0; t < 64; t++) begin
      s1 = rot_right(e, 6) ^ rot_right(e, 11) ^ rot_right(e, 25);
      t1 = h + s1 + ((e & f) ^ (~e & g)) + SHA_ROUND_K[t] + w[t];
      s0 = rot_right(a, 2) ^ rot_right(a, 13) ^ rot_right(a, 22);
      t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_hash[0] += a; chain_hash[1] += b; chain_hash[2] += c; chain_hash[3] += d;
    chain_hash[4] += e; chain_hash[5] += f; chain_hash[6] += g; chain_hash[7] += h;
  endtask

  // Applies one accepted item to the bench state and queues any digest items.
  task automatic hash_accept(input logic [1:0] op, input logic [7:0] value);
    int pos;
    case (op)
      sbsh_pkg::OP_START: begin
        chain_hash = SHA_START_HASH;
        fill_count = '0;
        msg_bits   = '0;
      end
      sbsh_pkg::OP_DATA: begin
        msg_block[fill_count] = value;
        msg_bits   = msg_bits + 64'd8;
        fill_count = fill_count + 6'd1;
        if (fill_count == 6'd0) compress_block();
      end
      sbsh_pkg::OP_FINISH: begin
        pos = fill_count;
        msg_block[pos] = 8'h80;
        pos++;
        // No room for the length: close this block and pad a fresh one.
        if (pos > 56) begin
          while (pos < 64) begin
            msg_block[pos] = 8'h00;
            pos++;
          end
          compress_block();
          pos = 0;
        end
        while (pos < 56) begin
          msg_block[pos] = 8'h00;
          pos++;
        end
        for (int i = 0; i < 8; i++) msg_block[56+i] = msg_bits[63-8*i -: 8];
        compress_block();
        fill_count = '0;
        for (int i = 0; i < 8; i++) begin
          digest_q.push_back('{word: chain_hash[i], index: 3'(i), last: (i == 7)});
        end
        words_due += 8;
      end
      default: begin
      end
    endcase
  endtask

  // Sender: bursts of items separated by random gaps.
  int unsigned burst_left = 4;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin : item_driver
    hash_item_t next_item;
    logic       offer_next;
    offer_next = 1'b0;
    if (rst_ni) begin
      if (in_valid && !in_stall) hash_accept(in_op, in_byte);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0 &&
                     !(pending_q[0].wait_idle && words_seen != words_due)) begin
          next_item  = pending_q.pop_front();
          offer_next = 1'b1;
          in_op   <= next_item.op;
          in_byte <= next_item.value;
          burst_left--;
          if (burst_left == 0) begin
            if ($urandom_range(0, 9) < 2) begin
              burst_left = $urandom_range(100, 300);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 16);
              gap_left   = $urandom_range(0, 10);
            end
          end
        end
        in_valid <= offer_next;
      end
    end
  end

  // Receiver stall: changing patterns plus one long hold-off.
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned stall_phase = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i) begin : stall_pattern
    if (rst_ni) begin
      stall_phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && words_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(20, 200);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (stall_phase % 3 == 0);
        endcase
      end
    end
  end

  // Digest checker.
  always @(posedge clk_i) begin : digest_monitor
    digest_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest item: digest_word %h word_index %0d", digest_word, word_index);
        mismatches++;
      end else begin
        want = digest_q.pop_front();
        if (digest_word !== want.word) begin
          $error("digest_word: expected %h, got %h", want.word, digest_word);
          mismatches++;
        end
        if (word_index !== want.index) begin
          $error("word_index: expected %0d, got %0d", want.index, word_index);
          mismatches++;
        end
        if (last_word !== want.last) begin
          $error("last_word: expected %0b, got %0b", want.last, last_word);
          mismatches++;
        end
      end
      words_seen <= words_seen + 1;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_item(input logic [1:0] op, input logic [7:0] value, input bit wait_idle);
    pending_q.push_back('{op: op, value: value, wait_idle: wait_idle});
    if (op != OP_UNUSED) planned_items++;
  endtask

  // A message with random content, sprinkled with ignored items and restarts.
  task automatic add_message(input int len, input bit with_start, input bit wait_idle);
    if (with_start) add_item(sbsh_pkg::OP_START, 8'($urandom), wait_idle);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 3) add_item(OP_UNUSED, 8'($urandom), 1'b0);
      if ($urandom_range(0, 99) < 1) add_item(sbsh_pkg::OP_START, 8'($urandom), 1'b0);
      add_item(sbsh_pkg::OP_DATA, 8'($urandom), 1'b0);
    end
    add_item(sbsh_pkg::OP_FINISH, 8'($urandom), 1'b0);
    if ($urandom_range(0, 19) == 0) add_item(sbsh_pkg::OP_FINISH, 8'($urandom), 1'b0);
  endtask

  initial begin : stimulus
    int len;
    int pick;
    bit with_start;

    // Finish straight after reset, with no start: the empty message.
    add_item(sbsh_pkg::OP_FINISH, 8'hff, 1'b0);
    add_item(OP_UNUSED, 8'hff, 1'b0);
    // Data and a double finish continuing from the previous digest.
    add_item(sbsh_pkg::OP_DATA, 8'h00, 1'b0);
    add_item(sbsh_pkg::OP_DATA, 8'hff, 1'b0);
    add_item(sbsh_pkg::OP_DATA, 8'h5a, 1'b0);
    add_item(sbsh_pkg::OP_FINISH, 8'h00, 1'b0);
    add_item(sbsh_pkg::OP_FINISH, 8'h00, 1'b0);
    // The message "abc".
    add_item(sbsh_pkg::OP_START, 8'h00, 1'b1);
    add_item(OP_UNUSED, 8'h00, 1'b0);
    add_item(sbsh_pkg::OP_DATA, 8'h61, 1'b0);
    add_item(sbsh_pkg::OP_DATA, 8'h62, 1'b0);
    add_item(sbsh_pkg::OP_DATA, 8'h63, 1'b0);
    add_item(sbsh_pkg::OP_FINISH, 8'h00, 1'b0);
    // Empty message after a start, then a single all-ones byte.
    add_item(sbsh_pkg::OP_START, 8'hff, 1'b0);
    add_item(sbsh_pkg::OP_FINISH, 8'hff, 1'b0);
    add_item(sbsh_pkg::OP_START, 8'h00, 1'b0);
    add_item(sbsh_pkg::OP_DATA, 8'hff, 1'b0);
    add_item(sbsh_pkg::OP_FINISH, 8'h00, 1'b0);

    // Lengths either side of the point where padding needs an extra block.
    add_message(55, 1'b1, 1'b1);
    add_message(56, 1'b1, 1'b0);
    add_message(63, 1'b1, 1'b0);
    add_message(64, 1'b1, 1'b0);

    while (planned_items < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = $urandom_range(0, 12);
      end else if (pick < 80) begin
        case ($urandom_range(0, 5))
          0: len = 54;
          1: len = 57;
          2: len = 62;
          3: len = 65;
          4: len = 119;
          default: len = 120;
        endcase
      end else begin
        len = $urandom_range(0, 140);
      end
      with_start = ($urandom_range(0, 9) != 0);
      add_message(len, with_start, with_start && ($urandom_range(0, 9) == 0));
    end

    // Wait for every item to go in and every digest item to come out.
    while (pending_q.size() != 0 || in_valid) @(negedge clk_i);
    while (words_seen < words_due) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (digest_q.size() != 0) begin
      $error("%0d digest items never arrived", digest_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
